>>> rtl/bft_pkg.sv
package bft_pkg;

  localparam int DefaultEntries = 256;
  localparam int KeyWidth = 97;
  localparam int CntWidth = 80;

  typedef enum logic [2:0] {
    OUT_SHORT   = 3'd0,
    OUT_NOT_IP4 = 3'd1,
    OUT_BAD_HDR = 3'd2,
    OUT_UNSUPP  = 3'd3,
    OUT_UPDATED = 3'd4,
    OUT_INSERT  = 3'd5,
    OUT_FULL    = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_UPDATE,
    ST_DONE
  } state_t;

  localparam logic [1:0] REG_LINK = 2'd0;

  function automatic logic is_private(input logic [31:0] a);
    is_private = (a[31:24] == 8'd10) || (a[31:20] == 12'hAC1) || (a[31:16] == 16'hC0A8);
  endfunction

endpackage

>>> rtl/bft_check.sv
module bft_check (
  input  logic        link_is_ethernet,
  input  logic [15:0] capture_length,
  input  logic [15:0] eth_type,
  input  logic [3:0]  ip_version,
  input  logic [3:0]  ip_header_words,
  input  logic [7:0]  ip_protocol,
  input  logic [15:0] ip_total_length,
  input  logic [3:0]  tcp_header_words,
  input  logic [15:0] udp_length,
  output logic        ok,
  output logic        udp,
  output bft_pkg::outcome_t reject,
  output logic [15:0] payload
);
  import bft_pkg::*;

  logic [16:0] need;
  logic [6:0]  hsum;

  always_comb begin
    ok = 1'b0;
    udp = (ip_protocol == 8'd17);
    reject = OUT_SHORT;
    payload = 16'd0;
    hsum = {1'b0, ip_header_words, 2'b00} + {1'b0, tcp_header_words, 2'b00};
    need = link_is_ethernet ? 17'd14 : 17'd0;
    if (link_is_ethernet && capture_length < 16'd14) begin
      reject = OUT_SHORT;
    end else if (link_is_ethernet && eth_type != 16'h0800) begin
      reject = OUT_NOT_IP4;
    end else if ({1'b0, capture_length} < need + 17'd20) begin
      reject = OUT_SHORT;
    end else if (ip_version != 4'd4) begin
      reject = OUT_NOT_IP4;
    end else if (ip_header_words < 4'd5) begin
      reject = OUT_BAD_HDR;
    end else if (ip_protocol == 8'd6) begin
      if ({1'b0, capture_length} < need + 17'd40) begin
        reject = OUT_SHORT;
      end else if (tcp_header_words < 4'd5) begin
        reject = OUT_BAD_HDR;
      end else begin
        ok = 1'b1;
        payload = (ip_total_length > {9'd0, hsum}) ? ip_total_length - {9'd0, hsum} : 16'd0;
      end
    end else if (udp) begin
      if ({1'b0, capture_length} < need + 17'd28) begin
        reject = OUT_SHORT;
      end else begin
        ok = 1'b1;
        payload = (udp_length > 16'd8) ? udp_length - 16'd8 : 16'd0;
      end
    end else begin
      reject = OUT_UNSUPP;
    end
  end

endmodule

>>> rtl/bft_table.sv
module bft_table #(
  parameter int Entries = bft_pkg::DefaultEntries,
  parameter int IdxW = $clog2(Entries)
) (
  input  logic                         clk,
  input  logic [IdxW-1:0]              rd_addr,
  output logic [bft_pkg::KeyWidth-1:0] rd_key,
  output logic [bft_pkg::CntWidth-1:0] rd_cnt,
  input  logic                         key_we,
  input  logic                         cnt_we,
  input  logic [IdxW-1:0]              wr_addr,
  input  logic [bft_pkg::KeyWidth-1:0] wr_key,
  input  logic [bft_pkg::CntWidth-1:0] wr_cnt
);
  import bft_pkg::*;

  logic [KeyWidth-1:0] key_mem [Entries];
  logic [CntWidth-1:0] cnt_mem [Entries];

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= wr_key;
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[wr_addr] <= wr_cnt;
    rd_cnt <= cnt_mem[rd_addr];
  end

endmodule

>>> rtl/bidirectional_flow_tracker.sv
// channel | dir | tdata (low bit up)                         | tuser
// s_axis  | in  | capture_length, eth_type, ip_version, ip_header_words, ip_protocol,
//         |     | ip_total_length, source_address, dest_address, source_port, dest_port,
//         |     | tcp_header_words, udp_length (180 bits, padded to 184) | -
// m_axis  | out | outcome, entry_index, entry_packets, entry_bytes, payload_bytes (112)
// apb     | cfg | reg 0 at 0x0: link_is_ethernet
// A packet's table scan reads one entry per stored flow, up to
// TABLE_ENTRIES: the table is read one entry a cycle from a
// single-port-read memory. Rejects and the first insert skip the scan.
// Reset clears the flow count and sets link_is_ethernet; table contents need no clear.
// The input is taken only when idle; results wait in the output register.
module bidirectional_flow_tracker #(
  parameter int TABLE_ENTRIES = bft_pkg::DefaultEntries
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [183:0] s_axis_tdata,   // see table above
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // outcome[2:0], index[10:3], packets[42:11],
                                       // bytes[90:43], payload[106:91]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bft_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = IdxW + 1;

  logic link;
  state_t state, state_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] ptr;
  logic [183:0] pkt;
  logic [2:0] res_outcome;
  logic [7:0] res_index;
  logic [31:0] res_packets;
  logic [47:0] res_bytes;
  logic [15:0] res_payload;

  logic ok, udp;
  outcome_t reject;
  logic [15:0] payload;

  logic [IdxW-1:0] rd_addr;
  logic [KeyWidth-1:0] rd_key;
  logic [CntWidth-1:0] rd_cnt;
  logic key_we, cnt_we;
  logic [IdxW-1:0] wr_addr;
  logic [KeyWidth-1:0] wr_key;
  logic [CntWidth-1:0] wr_cnt;

  logic [31:0] sa, da;
  logic [15:0] sp, dp;
  logic [IdxW-1:0] hit_idx;
  logic [CntW-1:0] chk;
  logic hit;
  logic [48:0] bsum;
  logic [31:0] pk_new;
  logic [47:0] by_new;

  assign pready = 1'b1;
  assign prdata = {31'd0, link};

  always_ff @(posedge clk) begin
    if (rst) begin
      link <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_LINK[0]) begin
      link <= pwdata[0];
    end
  end

  bft_check u_check (
    .link_is_ethernet(link),
    .capture_length(pkt[15:0]), .eth_type(pkt[31:16]), .ip_version(pkt[35:32]),
    .ip_header_words(pkt[39:36]), .ip_protocol(pkt[47:40]),
    .ip_total_length(pkt[63:48]), .tcp_header_words(pkt[163:160]),
    .udp_length(pkt[179:164]),
    .ok(ok), .udp(udp), .reject(reject), .payload(payload)
  );

  assign sa = pkt[95:64];
  assign da = pkt[127:96];
  assign sp = pkt[143:128];
  assign dp = pkt[159:144];

  bft_table #(.Entries(TABLE_ENTRIES), .IdxW(IdxW)) u_table (
    .clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_cnt(rd_cnt),
    .key_we(key_we), .cnt_we(cnt_we), .wr_addr(wr_addr), .wr_key(wr_key),
    .wr_cnt(wr_cnt)
  );

  assign rd_addr = ptr[IdxW-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_DONE);
  assign m_axis_tdata = {5'd0, res_payload, res_bytes, res_packets, res_index, res_outcome};

  // key layout: {udp, dport, sport, daddr, saddr}
  always_comb begin
    hit = (rd_key[96] == udp) &&
          ((rd_key[31:0] == sa && rd_key[79:64] == sp &&
            rd_key[63:32] == da && rd_key[95:80] == dp) ||
           (rd_key[31:0] == da && rd_key[79:64] == dp &&
            rd_key[63:32] == sa && rd_key[95:80] == sp));
    bsum = {1'b0, rd_cnt[79:32]} + {33'd0, payload};
    by_new = bsum[48] ? 48'hFFFF_FFFF_FFFF : bsum[47:0];
    pk_new = (rd_cnt[31:0] == 32'hFFFF_FFFF) ? rd_cnt[31:0] : rd_cnt[31:0] + 32'd1;
  end

  always_comb begin
    state_next = state;
    key_we = 1'b0;
    cnt_we = 1'b0;
    wr_addr = count[IdxW-1:0];
    if (is_private(da) && !is_private(sa)) begin
      wr_key = {udp, sp, dp, sa, da};
    end else begin
      wr_key = {udp, dp, sp, da, sa};
    end
    wr_cnt = {32'd0, payload, 32'd1};
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (!ok) state_next = ST_DONE;
        else if (count == '0) begin
          state_next = ST_DONE;
          key_we = 1'b1;
          cnt_we = 1'b1;
        end else state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) state_next = ST_UPDATE;
        else if (chk + 1'b1 >= count) begin
          state_next = ST_DONE;
          if (count < CntW'(TABLE_ENTRIES)) begin
            key_we = 1'b1;
            cnt_we = 1'b1;
          end
        end
      end
      ST_UPDATE: begin
        wr_addr = hit_idx;
        wr_cnt = {res_bytes, res_packets};
        cnt_we = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (key_we) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pkt <= s_axis_tdata;
        ptr <= '0;
      end
      ST_SCAN: begin
        chk <= '0;
        ptr <= ptr + 1'b1;
        res_outcome <= reject;
        res_index <= '0;
        res_packets <= '0;
        res_bytes <= '0;
        res_payload <= '0;
        if (ok && count == '0) begin
          res_outcome <= OUT_INSERT;
          res_index <= 8'(count);
          res_packets <= 32'd1;
          res_bytes <= {32'd0, payload};
          res_payload <= payload;
        end
      end
      ST_CHECK: begin
        ptr <= ptr + 1'b1;
        chk <= chk + 1'b1;
        hit_idx <= chk[IdxW-1:0];
        res_payload <= payload;
        if (hit) begin
          res_outcome <= OUT_UPDATED;
          res_index <= 8'(chk);
          res_packets <= pk_new;
          res_bytes <= by_new;
        end else if (chk + 1'b1 >= count) begin
          if (count < CntW'(TABLE_ENTRIES)) begin
            res_outcome <= OUT_INSERT;
            res_index <= 8'(count);
            res_packets <= 32'd1;
            res_bytes <= {32'd0, payload};
          end else begin
            res_outcome <= OUT_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TABLE_ENTRIES)) else $error("flow count overflow");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_write_once: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (count < CntW'(TABLE_ENTRIES))) else $error("insert into full table");

endmodule

>>> verif/tb.sv
module tb;
  import bft_pkg::*;

  localparam int Entries = 256;
  localparam int IdleLimit = 6000;
  localparam int PoolSize = 40;
  localparam logic [47:0] BytesMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] caplen;
    logic [15:0] etype;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] tot;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [3:0]  thl;
    logic [15:0] ulen;
  } pkt_t;

  typedef struct packed {
    outcome_t    oc;
    logic [7:0]  idx;
    logic [31:0] pk;
    logic [47:0] by;
    logic [15:0] pay;
  } flow_res_t;

  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        udp;
  } tuple_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  bidirectional_flow_tracker DUT (.*);

  // tracker copy
  logic        link_eth;
  int          flow_count;
  logic [31:0] f_sa [Entries];
  logic [31:0] f_da [Entries];
  logic [15:0] f_sp [Entries];
  logic [15:0] f_dp [Entries];
  logic        f_udp [Entries];
  logic [31:0] f_pk [Entries];
  logic [47:0] f_by [Entries];

  flow_res_t   flow_results_q[$];
  tuple_t      pool[PoolSize];
  int          errors;
  int          hold_cycles;
  int          idle_count;
  int          tx_burst;
  int          rx_burst;
  int          uniq;

  always begin
    clk = 0;
    #10;
    clk = 1;
    #10;
  end

  function automatic logic addr_private(input logic [31:0] a);
    return (a[31:24] == 8'd10) || (a[31:20] == 12'hAC1) || (a[31:16] == 16'hC0A8);
  endfunction

  function automatic flow_res_t track_packet(input pkt_t p);
    flow_res_t   r;
    int          off;
    int          ihlb;
    int          thlb;
    int          pay;
    logic        udp;
    logic        hit;
    int          slot;
    logic [48:0] sum;
    logic        fwd;
    logic        rev;
    r.oc = OUT_SHORT;
    r.idx = '0;
    r.pk = '0;
    r.by = '0;
    r.pay = '0;
    ihlb = p.ihl * 4;
    thlb = p.thl * 4;
    off = link_eth ? 14 : 0;
    hit = 0;
    slot = 0;
    if (link_eth && p.caplen < 14) r.oc = OUT_SHORT;
    else if (link_eth && p.etype != 16'h0800) r.oc = OUT_NOT_IP4;
    else if (p.caplen < off + 20) r.oc = OUT_SHORT;
    else if (p.ver != 4'd4) r.oc = OUT_NOT_IP4;
    else if (ihlb < 20) r.oc = OUT_BAD_HDR;
    else if (p.proto == 8'd6 && p.caplen < off + 40) r.oc = OUT_SHORT;
    else if (p.proto == 8'd6 && thlb < 20) r.oc = OUT_BAD_HDR;
    else if (p.proto == 8'd17 && p.caplen < off + 28) r.oc = OUT_SHORT;
    else if (p.proto != 8'd6 && p.proto != 8'd17) r.oc = OUT_UNSUPP;
    else begin
      if (p.proto == 8'd6) begin
        udp = 0;
        pay = (p.tot > ihlb + thlb) ? p.tot - (ihlb + thlb) : 0;
      end else begin
        udp = 1;
        pay = (p.ulen > 8) ? p.ulen - 8 : 0;
      end
      for (int i = 0; i < flow_count; i++) begin
        fwd = f_sa[i] == p.sa && f_sp[i] == p.sp && f_da[i] == p.da && f_dp[i] == p.dp;
        rev = f_sa[i] == p.da && f_sp[i] == p.dp && f_da[i] == p.sa && f_dp[i] == p.sp;
        if (!hit && f_udp[i] == udp && (fwd || rev)) begin
          hit = 1;
          slot = i;
        end
      end
      r.pay = pay[15:0];
      if (hit) begin
        sum = {1'b0, f_by[slot]} + 49'(pay);
        f_by[slot] = (sum > {1'b0, BytesMax}) ? BytesMax : sum[47:0];
        if (f_pk[slot] != 32'hFFFF_FFFF) f_pk[slot] = f_pk[slot] + 1;
        r.oc = OUT_UPDATED;
        r.idx = slot[7:0];
        r.pk = f_pk[slot];
        r.by = f_by[slot];
      end else if (flow_count >= Entries) begin
        r.oc = OUT_FULL;
      end else begin
        slot = flow_count;
        if (addr_private(p.da) && !addr_private(p.sa)) begin
          f_sa[slot] = p.da;
          f_da[slot] = p.sa;
          f_sp[slot] = p.dp;
          f_dp[slot] = p.sp;
        end else begin
          f_sa[slot] = p.sa;
          f_da[slot] = p.da;
          f_sp[slot] = p.sp;
          f_dp[slot] = p.dp;
        end
        f_udp[slot] = udp;
        f_pk[slot] = 1;
        f_by[slot] = 48'(pay);
        flow_count++;
        r.oc = OUT_INSERT;
        r.idx = slot[7:0];
        r.pk = 1;
        r.by = 48'(pay);
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic send_pkt(input pkt_t p);
    int gap;
    if (tx_burst > 0) tx_burst--;
    else if ($urandom_range(0, 15) == 0) tx_burst = 20;
    gap = (tx_burst > 0) ? 0 : $urandom_range(0, 3);
    repeat (gap) @(negedge clk) s_axis_tvalid <= 0;
    @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'd0, p.ulen, p.thl, p.dp, p.sp, p.da, p.sa, p.tot, p.proto,
                     p.ihl, p.ver, p.etype, p.caplen};
    do @(posedge clk); while (!s_axis_tready);
    flow_results_q.insert(flow_results_q.size(), track_packet(p));
    @(negedge clk) s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    @(negedge clk) s_axis_tvalid <= 0;
    wait (flow_results_q.size() == 0);
    repeat (Entries + 10) @(posedge clk);
  endtask

  task automatic write_link(input logic eth);
    drain();
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {1'b0, REG_LINK} << 2;
    pwdata <= {31'd0, eth};
    @(negedge clk) penable <= 1;
    do @(posedge clk); while (!pready);
    link_eth = eth;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  function automatic pkt_t good_pkt(input tuple_t t);
    pkt_t p;
    int   base;
    base = link_eth ? 54 : 40;
    p.caplen = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(base, 1600));
    p.etype = 16'h0800;
    p.ver = 4'd4;
    p.ihl = 4'($urandom_range(5, 15));
    p.proto = t.udp ? 8'd17 : 8'd6;
    p.tot = 16'($urandom());
    p.thl = 4'($urandom_range(5, 15));
    p.ulen = 16'($urandom());
    if ($urandom_range(0, 1)) begin
      p.sa = t.sa; p.da = t.da; p.sp = t.sp; p.dp = t.dp;
    end else begin
      p.sa = t.da; p.da = t.sa; p.sp = t.dp; p.dp = t.sp;
    end
    return p;
  endfunction

  function automatic tuple_t rand_tuple();
    tuple_t t;
    t.sa = $urandom();
    t.da = $urandom();
    case ($urandom_range(0, 3))
      0: t.sa[31:24] = 8'd10;
      1: t.da[31:20] = 12'hAC1;
      2: t.da[31:16] = 16'hC0A8;
      default: ;
    endcase
    t.sp = 16'($urandom());
    t.dp = 16'($urandom());
    t.udp = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic pkt_t noise_pkt();
    pkt_t         p;
    logic [191:0] raw;
    p = good_pkt(pool[$urandom_range(0, PoolSize - 1)]);
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: p = pkt_t'(raw[179:0]);
      1: p.caplen = 16'($urandom_range(0, 60));
      2: p.etype = 16'($urandom());
      3: p.ver = 4'($urandom());
      4: p.ihl = 4'($urandom_range(0, 4));
      5: p.proto = 8'($urandom());
      6: p.thl = 4'($urandom_range(0, 4));
      default: p.ulen = 16'($urandom_range(0, 8));
    endcase
    return p;
  endfunction

  function automatic pkt_t mk(input int caplen, input int etype, input int ver, input int ihl,
                              input int proto, input int tot, input logic [31:0] sa,
                              input logic [31:0] da, input int sp, input int dp,
                              input int thl, input int ulen);
    pkt_t p;
    p.caplen = 16'(caplen); p.etype = 16'(etype); p.ver = 4'(ver); p.ihl = 4'(ihl);
    p.proto = 8'(proto); p.tot = 16'(tot); p.sa = sa; p.da = da; p.sp = 16'(sp);
    p.dp = 16'(dp); p.thl = 4'(thl); p.ulen = 16'(ulen);
    return p;
  endfunction

  task automatic test_directed_ethernet();
    send_pkt(mk(0, 'h0800, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(13, 'h0800, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(14, 'h86DD, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(33, 'h0800, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(60, 'h0800, 6, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(60, 'h0800, 4, 4, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(60, 'h0800, 4, 5, 1, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(53, 'h0800, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(54, 'h0800, 4, 5, 6, 100, 1, 2, 3, 4, 4, 0));
    send_pkt(mk(54, 'h0800, 4, 5, 6, 100, 32'h0A000001, 32'h08080808, 1000, 80, 5, 0));
    send_pkt(mk(54, 'h0800, 4, 5, 6, 30, 32'h08080808, 32'h0A000001, 80, 1000, 5, 0));
    send_pkt(mk(41, 'h0800, 4, 5, 17, 0, 32'h0A000001, 32'h08080808, 1000, 80, 0, 50));
    send_pkt(mk(42, 'h0800, 4, 5, 17, 0, 32'h0A000001, 32'h08080808, 1000, 80, 0, 50));
    send_pkt(mk(42, 'h0800, 4, 15, 17, 0, 32'h0A000001, 32'h08080808, 1000, 80, 0, 3));
    send_pkt(mk(100, 'h0800, 4, 5, 6, 500, 32'h01020304, 32'hC0A80001, 5, 6, 5, 0));
    send_pkt(mk(100, 'h0800, 4, 5, 17, 0, 32'hAC100001, 32'hC0A80001, 7, 8, 0, 9));
    send_pkt(mk('hFFFF, 'h0800, 4, 15, 6, 'hFFFF, '1, '1, 'hFFFF, 'hFFFF, 15, 'hFFFF));
    send_pkt(mk('hFFFF, 'hFFFF, 15, 15, 'hFF, 'hFFFF, '1, '1, 'hFFFF, 'hFFFF, 15, 'hFFFF));
  endtask

  task automatic test_directed_raw();
    write_link(0);
    send_pkt(mk(19, 'hFFFF, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(20, 'hFFFF, 4, 5, 1, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(39, 'h0000, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(40, 'h0000, 4, 5, 6, 100, 1, 2, 3, 4, 5, 0));
    send_pkt(mk(27, 'h1234, 4, 5, 17, 0, 1, 2, 3, 4, 0, 20));
    send_pkt(mk(28, 'h1234, 4, 5, 17, 0, 2, 1, 4, 3, 0, 20));
    write_link(1);
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 9) < 7) send_pkt(good_pkt(pool[$urandom_range(0, PoolSize - 1)]));
      else send_pkt(noise_pkt());
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    test_random_traffic(30);
    wait (flow_results_q.size() == 0);
    test_random_traffic(30);
  endtask

  task automatic test_table_full(input int n);
    tuple_t t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        test_random_traffic(1);
      end else begin
        t = rand_tuple();
        t.sp = 16'(uniq++);
        send_pkt(good_pkt(t));
      end
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    link_eth = 1;
    flow_count = 0;
    errors = 0;
    hold_cycles = 0;
    tx_burst = 0;
    rx_burst = 0;
    uniq = 0;
    for (int i = 0; i < PoolSize; i++) pool[i] = rand_tuple();
    repeat (10) @(negedge clk);
    rst <= 0;
    test_directed_ethernet();
    test_directed_raw();
    write_link(1);
    test_random_traffic(300);
    write_link(0);
    test_random_traffic(300);
    test_backpressure();
    write_link(1);
    test_random_traffic(300);
    write_link(1'($urandom_range(0, 1)));
    test_table_full(600);
    drain();
    if (errors == 0) $display("bidirectional_flow_tracker verification clean");
    else $display("bidirectional_flow_tracker verification failed");
    $finish;
  end

  initial begin
    int gap;
    m_axis_tready = 0;
    forever begin
      if (hold_cycles > 0) begin
        repeat (hold_cycles) @(negedge clk) m_axis_tready <= 0;
        hold_cycles = 0;
      end
      if (rx_burst > 0) rx_burst--;
      else if ($urandom_range(0, 15) == 0) rx_burst = 20;
      gap = (rx_burst > 0) ? 0 : $urandom_range(0, 3);
      repeat (gap) @(negedge clk) m_axis_tready <= 0;
      @(negedge clk) m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    flow_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (flow_results_q.size() == 0) begin
        report("unexpected result", m_axis_tdata[63:0], 0);
      end else begin
        want = flow_results_q.pop_front();
        if (m_axis_tdata[2:0] != want.oc) report("outcome", m_axis_tdata[2:0], want.oc);
        if (m_axis_tdata[10:3] != want.idx) report("entry_index", m_axis_tdata[10:3], want.idx);
        if (m_axis_tdata[42:11] != want.pk) report("entry_packets", m_axis_tdata[42:11], want.pk);
        if (m_axis_tdata[90:43] != want.by) report("entry_bytes", m_axis_tdata[90:43], want.by);
        if (m_axis_tdata[106:91] != want.pay)
          report("payload_bytes", m_axis_tdata[106:91], want.pay);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (flow_results_q.size() == 0 && !s_axis_tvalid && !psel)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IdleLimit) begin
        $display("bidirectional_flow_tracker verification failed");
        $finish;
      end
    end
  end

endmodule

>>> bidirectional_flow_tracker.f
rtl/bft_pkg.sv
rtl/bft_check.sv
rtl/bft_table.sv
rtl/bidirectional_flow_tracker.sv
verif/tb.sv
